/* design/btnf_pkg.sv */
package btnf_pkg;

    localparam int DEF_HEAP_BYTES = 65536;
    localparam int INIT_CHUNK     = 1 << 12;
    localparam int WSIZE          = 4;
    localparam int DSIZE          = 8;
    localparam int MIN_BLOCK      = 2 * DSIZE;

    localparam int CHUNK_W = 17;
    localparam int REQ_W   = 16;
    localparam int OFF_W   = 16;
    localparam int ST_W    = 2;
    localparam int ASIZE_W = 17;

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd2;

endpackage

/* design/btnf_ram.sv */
module btnf_ram
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
)
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* design/boundary_tag_next_fit_allocator_unit.sv */
// Boundary-tag heap allocator with next-fit search over an on-chip word
// memory of HEAP_BYTES bytes. Each block carries a 4-byte header and footer
// (size in multiples of 8, bit 0 = allocated). An allocate word (op 0) is
// rounded up to a block size, searched from the rover to the end of the heap
// and then once from the heap start, split when the remainder is 16 bytes or
// more, or served by growing the heap by max(size, chunk_bytes); the answer
// is the payload offset, or status 1 for a zero-size request and status 2
// when the heap is full. A free word (op 1) answers offset 0 / status 0 and
// releases the block only if it is a currently allocated payload, merging it
// with free neighbors. Timing: one item at a time. An allocate passes the
// accept state and one memory read per block header during the search (the
// epilogue read that ends a pass included); when the heap must grow, a
// check, three tag writes and the merge follow. Then two tag writes mark a
// block taken whole, or four split it, and the result is handed over. A
// free passes the accept state, one read per block walked up to the freed
// one, two writes that clear its tags, the merge and the handover. A stalled
// result holds the unit in the handover state. After reset the unit clears
// the whole memory, one word per cycle, then writes the prologue, the first
// 4096-byte free block (when the heap has room for it) and the epilogue;
// input stays stalled meanwhile. chunk_bytes may be written only while idle;
// it takes effect at the next allocate.
module boundary_tag_next_fit_allocator_unit
    import btnf_pkg::*;
#(
    parameter int HEAP_BYTES = DEF_HEAP_BYTES
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [0:0]         i_op,
    input  logic [REQ_W-1:0]   i_request_bytes,
    input  logic [OFF_W-1:0]   i_free_offset,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OFF_W-1:0]   o_block_offset,
    output logic [ST_W-1:0]    o_status,
    input  logic               i_cfg_we,
    input  logic [CHUNK_W-1:0] i_cfg_data
);

    localparam int HW = HEAP_BYTES / 4;
    localparam int AW = $clog2(HW);
    localparam int BW = $clog2(HEAP_BYTES) + 1;          // byte offsets up to HEAP_BYTES
    localparam int GW = ((BW > 18) ? BW : 18) + 1;       // growth checks
    localparam int CW = (BW > OFF_W) ? BW : OFF_W;       // offset compares
    localparam bit INIT_FITS = (HEAP_BYTES >= 16 + INIT_CHUNK);

    localparam logic [BW-1:0] B_W    = BW'(WSIZE);
    localparam logic [BW-1:0] B_D    = BW'(DSIZE);
    localparam logic [BW-1:0] B_MIN  = BW'(MIN_BLOCK);
    localparam logic [BW-1:0] B_MASK = ~BW'(7);
    localparam logic [BW-1:0] END_RST   = INIT_FITS ? BW'(16 + INIT_CHUNK) : BW'(16);
    localparam logic [BW-1:0] ROVER_RST = INIT_FITS ? BW'(16) : BW'(8);

    typedef enum logic [23:0] {
        S_CLR   = 24'h000001,
        S_INIT  = 24'h000002,
        S_IDLE  = 24'h000004,
        S_SRD   = 24'h000008,
        S_SEV   = 24'h000010,
        S_GCHK  = 24'h000020,
        S_GW0   = 24'h000040,
        S_GW1   = 24'h000080,
        S_GW2   = 24'h000100,
        S_MPRD  = 24'h000200,
        S_MPEV  = 24'h000400,
        S_MNEV  = 24'h000800,
        S_MCALC = 24'h001000,
        S_MW0   = 24'h002000,
        S_MW1   = 24'h004000,
        S_P0    = 24'h008000,
        S_P1    = 24'h010000,
        S_P2    = 24'h020000,
        S_P3    = 24'h040000,
        S_FRD   = 24'h080000,
        S_FEV   = 24'h100000,
        S_FW0   = 24'h200000,
        S_FW1   = 24'h400000,
        S_DONE  = 24'h800000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]      r_clr, n_clr;
    logic [2:0]         r_init, n_init;
    logic [BW-1:0]      r_heap_end, n_heap_end;
    logic [BW-1:0]      r_rover, n_rover;
    logic [CHUNK_W-1:0] r_chunk;
    logic [BW-1:0]      r_p, n_p;
    logic               r_pass, n_pass;
    logic               r_from_free, n_from_free;
    logic [ASIZE_W-1:0] r_asize, n_asize;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [BW-1:0]      r_bp, n_bp;
    logic [BW-1:0]      r_csize, n_csize;
    logic               r_pf_free, n_pf_free;
    logic [BW-1:0]      r_pf_sz, n_pf_sz;
    logic               r_nh_free, n_nh_free;
    logic [BW-1:0]      r_nh_sz, n_nh_sz;
    logic [BW-1:0]      r_start, n_start;
    logic [BW-1:0]      r_total, n_total;
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    logic [ST_W-1:0]    r_res_st, n_res_st;
    logic               r_ovalid;
    logic [OFF_W-1:0]   r_out_off;
    logic [ST_W-1:0]    r_out_st;
    logic               r_rd_oob;

    // memory port signals
    logic          mem_we;
    logic [BW-1:0] mem_wbyte;
    logic [31:0]   mem_wdata;
    logic [BW-1:0] mem_rbyte;
    logic [31:0]   ram_q;
    logic [31:0]   rdat;
    logic          w_in_range;
    logic          r_in_range;

    // decoded tag from the last read
    logic [BW-1:0] q_sz;
    logic          q_alloc;

    // place split
    logic [BW-1:0] rem;
    logic          split;

    // growth sizing
    logic [CHUNK_W-1:0] g_bytes;
    logic [15:0]        g_words;
    logic [17:0]        g_size;
    logic               g_fail;

    logic accept;
    logic out_free;

    assign w_in_range = (GW'(mem_wbyte >> 2) < GW'(HW));
    assign r_in_range = (GW'(mem_rbyte >> 2) < GW'(HW));

    btnf_ram #(
        .DEPTH (HW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we && w_in_range),
        .i_waddr (mem_wbyte[AW+1:2]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_rbyte[AW+1:2]),
        .o_rdata (ram_q)
    );

    // out-of-heap reads see zero
    assign rdat    = r_rd_oob ? 32'd0 : ram_q;
    assign q_sz    = rdat[BW-1:0] & B_MASK;
    assign q_alloc = rdat[0];

    assign rem   = r_csize - BW'(r_asize);
    assign split = (rem >= B_MIN);

    assign g_bytes = (CHUNK_W'(r_asize) > r_chunk) ? CHUNK_W'(r_asize) : r_chunk;
    assign g_words = (16'(g_bytes >> 2) + 16'd1) & ~16'd1;
    assign g_size  = {g_words, 2'b00};
    assign g_fail  = (GW'(g_size) > GW'(HEAP_BYTES))
                  || (GW'(r_heap_end) + GW'(g_size) > GW'(HEAP_BYTES));

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_block_offset = r_out_off;
    assign o_status       = r_out_st;

    // memory address and data per state
    always_comb begin
        mem_we    = 1'b0;
        mem_wbyte = '0;
        mem_wdata = '0;
        mem_rbyte = '0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wbyte = BW'({r_clr, 2'b00});
            end
            S_INIT: begin
                mem_we = 1'b1;
                case (r_init)
                    3'd0: begin
                        mem_wbyte = BW'(4);
                        mem_wdata = 32'(DSIZE + 1);
                    end
                    3'd1: begin
                        mem_wbyte = BW'(8);
                        mem_wdata = 32'(DSIZE + 1);
                    end
                    3'd2: begin
                        mem_wbyte = BW'(12);
                        mem_wdata = INIT_FITS ? 32'(INIT_CHUNK) : 32'd1;
                    end
                    3'd3: begin
                        mem_wbyte = BW'(16 + INIT_CHUNK - 8);
                        mem_wdata = 32'(INIT_CHUNK);
                    end
                    default: begin
                        mem_wbyte = BW'(16 + INIT_CHUNK - 4);
                        mem_wdata = 32'd1;
                    end
                endcase
            end
            S_SRD, S_FRD: begin
                mem_rbyte = r_p - B_W;
            end
            S_GW0: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp - B_W;
                mem_wdata = 32'(r_csize);
            end
            S_GW1: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp + r_csize - B_D;
                mem_wdata = 32'(r_csize);
            end
            S_GW2: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp + r_csize - B_W;
                mem_wdata = 32'd1;
            end
            S_MPRD: begin
                mem_rbyte = r_bp - B_D;
            end
            S_MPEV: begin
                mem_rbyte = r_bp + r_csize - B_W;
            end
            S_MW0: begin
                mem_we    = 1'b1;
                mem_wbyte = r_start - B_W;
                mem_wdata = 32'(r_total);
            end
            S_MW1: begin
                mem_we    = 1'b1;
                mem_wbyte = r_start + r_total - B_D;
                mem_wdata = 32'(r_total);
            end
            S_P0: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp - B_W;
                mem_wdata = split ? 32'({r_asize[ASIZE_W-1:1], 1'b1})
                                  : 32'({r_csize[BW-1:1], 1'b1});
            end
            S_P1: begin
                mem_we    = 1'b1;
                mem_wbyte = split ? (r_bp + BW'(r_asize) - B_D) : (r_bp + r_csize - B_D);
                mem_wdata = split ? 32'({r_asize[ASIZE_W-1:1], 1'b1})
                                  : 32'({r_csize[BW-1:1], 1'b1});
            end
            S_P2: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp + BW'(r_asize) - B_W;
                mem_wdata = 32'(rem);
            end
            S_P3: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp + r_csize - B_D;
                mem_wdata = 32'(rem);
            end
            S_FW0: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp - B_W;
                mem_wdata = 32'(r_csize);
            end
            S_FW1: begin
                mem_we    = 1'b1;
                mem_wbyte = r_bp + r_csize - B_D;
                mem_wdata = 32'(r_csize);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_init      = r_init;
        n_heap_end  = r_heap_end;
        n_rover     = r_rover;
        n_p         = r_p;
        n_pass      = r_pass;
        n_from_free = r_from_free;
        n_asize     = r_asize;
        n_off       = r_off;
        n_bp        = r_bp;
        n_csize     = r_csize;
        n_pf_free   = r_pf_free;
        n_pf_sz     = r_pf_sz;
        n_nh_free   = r_nh_free;
        n_nh_sz     = r_nh_sz;
        n_start     = r_start;
        n_total     = r_total;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        case (r_state)
            S_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(HW - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_init = r_init + 3'd1;
                if (r_init == (INIT_FITS ? 3'd4 : 3'd2)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_off = '0;
                    n_res_st  = ST_OK;
                    if (i_op == OP_FREE) begin
                        n_from_free = 1'b1;
                        n_p         = B_MIN;
                        n_off       = i_free_offset;
                        n_state     = S_FRD;
                    end else if (i_request_bytes == '0) begin
                        n_res_st = ST_ZERO;
                        n_state  = S_DONE;
                    end else begin
                        n_from_free = 1'b0;
                        n_asize     = (i_request_bytes <= REQ_W'(DSIZE))
                                    ? ASIZE_W'(MIN_BLOCK)
                                    : (ASIZE_W'(i_request_bytes) + ASIZE_W'(15))
                                      & ~ASIZE_W'(7);
                        n_p         = r_rover;
                        n_pass      = 1'b0;
                        n_state     = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if ((r_p <= r_heap_end) && !(r_pass && (r_p == r_rover))) begin
                    n_state = S_SEV;
                end else if (!r_pass) begin
                    n_pass = 1'b1;
                    n_p    = B_D;
                end else begin
                    n_state = S_GCHK;
                end
            end
            S_SEV: begin
                if (q_sz == '0) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_p     = B_D;
                        n_state = S_SRD;
                    end else begin
                        n_state = S_GCHK;
                    end
                end else if (!q_alloc && (GW'(r_asize) <= GW'(q_sz))) begin
                    n_bp    = r_p;
                    n_csize = q_sz;
                    n_state = S_P0;
                end else begin
                    n_p     = r_p + q_sz;
                    n_state = S_SRD;
                end
            end
            S_GCHK: begin
                if (g_fail) begin
                    n_res_st = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_bp    = r_heap_end;
                    n_csize = BW'(g_size);
                    n_state = S_GW0;
                end
            end
            S_GW0: n_state = S_GW1;
            S_GW1: n_state = S_GW2;
            S_GW2: begin
                n_heap_end = r_heap_end + r_csize;
                n_state    = S_MPRD;
            end
            S_MPRD: n_state = S_MPEV;
            S_MPEV: begin
                n_pf_free = !q_alloc;
                n_pf_sz   = q_sz;
                if (r_from_free) begin
                    n_state = S_MNEV;
                end else begin
                    // the new chunk is followed by the fresh epilogue
                    n_nh_free = 1'b0;
                    n_state   = S_MCALC;
                end
            end
            S_MNEV: begin
                n_nh_free = !q_alloc;
                n_nh_sz   = q_sz;
                n_state   = S_MCALC;
            end
            S_MCALC: begin
                n_start = r_pf_free ? (r_bp - r_pf_sz) : r_bp;
                n_total = r_csize + (r_pf_free ? r_pf_sz : '0) + (r_nh_free ? r_nh_sz : '0);
                n_state = S_MW0;
            end
            S_MW0: n_state = S_MW1;
            S_MW1: begin
                n_rover = r_start;
                if (r_from_free) begin
                    n_state = S_DONE;
                end else begin
                    n_bp    = r_start;
                    n_csize = r_total;
                    n_state = S_P0;
                end
            end
            S_P0: n_state = S_P1;
            S_P1: begin
                if (split) begin
                    n_state = S_P2;
                end else begin
                    n_rover   = r_bp;
                    n_res_off = OFF_W'(r_bp);
                    n_state   = S_DONE;
                end
            end
            S_P2: n_state = S_P3;
            S_P3: begin
                n_rover   = r_bp;
                n_res_off = OFF_W'(r_bp);
                n_state   = S_DONE;
            end
            S_FRD: begin
                if (r_p < r_heap_end) begin
                    n_state = S_FEV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FEV: begin
                if (q_sz == '0) begin
                    n_state = S_DONE;
                end else if (CW'(r_p) == CW'(r_off)) begin
                    if (q_alloc) begin
                        n_bp    = r_p;
                        n_csize = q_sz;
                        n_state = S_FW0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (CW'(r_p) > CW'(r_off)) begin
                    n_state = S_DONE;
                end else begin
                    n_p     = r_p + q_sz;
                    n_state = S_FRD;
                end
            end
            S_FW0: n_state = S_FW1;
            S_FW1: n_state = S_MPRD;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_init     <= '0;
            r_heap_end <= END_RST;
            r_rover    <= ROVER_RST;
            r_chunk    <= CHUNK_W'(INIT_CHUNK);
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_init     <= n_init;
            r_heap_end <= n_heap_end;
            r_rover    <= n_rover;
            if (i_cfg_we) begin
                r_chunk <= i_cfg_data;
            end
            // hold a stalled result, load a new one when the slot opens
            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_pass      <= n_pass;
        r_from_free <= n_from_free;
        r_asize     <= n_asize;
        r_off       <= n_off;
        r_bp        <= n_bp;
        r_csize     <= n_csize;
        r_pf_free   <= n_pf_free;
        r_pf_sz     <= n_pf_sz;
        r_nh_free   <= n_nh_free;
        r_nh_sz     <= n_nh_sz;
        r_start     <= n_start;
        r_total     <= n_total;
        r_res_off   <= n_res_off;
        r_res_st    <= n_res_st;
        r_rd_oob    <= !r_in_range;
        if ((r_state == S_DONE) && out_free) begin
            r_out_off <= r_res_off;
            r_out_st  <= r_res_st;
        end
    end

endmodule

/* test/btnf_checker.sv */
module btnf_checker
    import btnf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [0:0]         i_op,
    input  logic [REQ_W-1:0]   i_request_bytes,
    input  logic [OFF_W-1:0]   i_free_offset,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [OFF_W-1:0]   i_block_offset,
    input  logic [ST_W-1:0]    i_status,
    input  logic               i_cfg_we,
    input  logic [CHUNK_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP_WORDS = DEF_HEAP_BYTES / WSIZE;
    localparam int unsigned WALK_MAX   = DEF_HEAP_BYTES / 8 + 4;
    localparam int unsigned SZ_MASK    = 32'hFFFF_FFF8;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [ST_W-1:0]  status;
    } answer_t;

    logic [31:0] heap_words [HEAP_WORDS];
    int unsigned heap_top;
    int unsigned next_fit_start;
    int unsigned min_growth;
    answer_t     answers_due [$];

    function automatic int unsigned tag_rd(int unsigned addr);
        int unsigned idx;
        idx = addr >> 2;
        return (idx < HEAP_WORDS) ? heap_words[idx] : 0;
    endfunction

    function automatic void tag_wr(int unsigned addr, int unsigned v);
        int unsigned idx;
        idx = addr >> 2;
        if (idx < HEAP_WORDS) heap_words[idx] = v;
    endfunction

    function automatic int unsigned size_of(int unsigned bp);
        return tag_rd(bp - 4) & SZ_MASK;
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz, prev_ftr, next_hdr, head, total;
        sz = size_of(bp);
        prev_ftr = tag_rd(bp - 8);
        next_hdr = tag_rd(bp + sz - 4);
        head = bp;
        total = sz;
        if (!prev_ftr[0]) begin
            head = bp - (prev_ftr & SZ_MASK);
            total += prev_ftr & SZ_MASK;
        end
        if (!next_hdr[0]) total += next_hdr & SZ_MASK;
        tag_wr(head - 4, total);
        tag_wr(head + total - 8, total);
        next_fit_start = head;
        return head;
    endfunction

    function automatic int unsigned grow_heap(int unsigned sz);
        int unsigned bp;
        bp = heap_top;
        if (sz > DEF_HEAP_BYTES || heap_top > DEF_HEAP_BYTES - sz) return 0;
        tag_wr(bp - 4, sz);
        tag_wr(bp + sz - 8, sz);
        tag_wr(bp + sz - 4, 1);
        heap_top += sz;
        return coalesce(bp);
    endfunction

    function automatic bit block_fits(int unsigned bp, int unsigned need);
        int unsigned h;
        h = tag_rd(bp - 4);
        return !h[0] && need <= (h & SZ_MASK);
    endfunction

    // Next fit: rover to epilogue, then wrap once from the heap start.
    function automatic int unsigned find_fit(int unsigned need);
        int unsigned p, sz;
        p = next_fit_start;
        for (int unsigned n = 0; n < WALK_MAX && p <= heap_top; n++) begin
            sz = size_of(p);
            if (sz == 0) break;
            if (block_fits(p, need)) return p;
            p += sz;
        end
        p = 8;
        for (int unsigned n = 0; n < WALK_MAX && p != next_fit_start && p <= heap_top;
             n++) begin
            sz = size_of(p);
            if (sz == 0) break;
            if (block_fits(p, need)) return p;
            p += sz;
        end
        return 0;
    endfunction

    function automatic void carve(int unsigned bp, int unsigned need);
        int unsigned have;
        have = size_of(bp);
        if (have - need < MIN_BLOCK) begin
            tag_wr(bp - 4, have | 1);
            tag_wr(bp + have - 8, have | 1);
        end else begin
            tag_wr(bp - 4, need | 1);
            tag_wr(bp + need - 8, need | 1);
            tag_wr(bp + need - 4, have - need);
            tag_wr(bp + have - 8, have - need);
        end
        next_fit_start = bp;
    endfunction

    function automatic bit is_live_payload(int unsigned off);
        int unsigned p, h, sz;
        p = 16;
        for (int unsigned n = 0; n < WALK_MAX && p < heap_top; n++) begin
            h = tag_rd(p - 4);
            sz = h & SZ_MASK;
            if (sz == 0) return 0;
            if (p == off) return h[0];
            if (p > off) return 0;
            p += sz;
        end
        return 0;
    endfunction

    function automatic void heap_init();
        foreach (heap_words[i]) heap_words[i] = '0;
        min_growth = INIT_CHUNK;
        tag_wr(4, 9);
        tag_wr(8, 9);
        tag_wr(12, 1);
        heap_top = 16;
        next_fit_start = 8;
        void'(grow_heap(INIT_CHUNK));
    endfunction

    function automatic answer_t predict_answer(logic [0:0] op, int unsigned req,
                                               int unsigned off);
        answer_t a;
        int unsigned sz, need, grow_by, bp;
        a.offset = '0;
        a.status = ST_OK;
        if (op == OP_FREE) begin
            if (is_live_payload(off)) begin
                sz = size_of(off);
                tag_wr(off - 4, sz);
                tag_wr(off + sz - 8, sz);
                bp = coalesce(off);
            end
            return a;
        end
        if (req == 0) begin
            a.status = ST_ZERO;
            return a;
        end
        need = (req <= DSIZE) ? MIN_BLOCK : ((req + 15) & SZ_MASK);
        bp = find_fit(need);
        if (bp == 0) begin
            grow_by = (need > min_growth) ? need : min_growth;
            bp = grow_heap((((grow_by >> 2) + 1) & ~32'd1) << 2);
            if (bp == 0) begin
                a.status = ST_OOM;
                return a;
            end
        end
        carve(bp, need);
        a.offset = bp[OFF_W-1:0];
        return a;
    endfunction

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        answer_t want;
        if (!i_rst_n) begin
            heap_init();
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) min_growth = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(predict_answer(i_op, i_request_bytes, i_free_offset));
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word: offset %0d status %0d",
                                 i_block_offset, i_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want.offset !== i_block_offset || want.status !== i_status) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected offset %0d status %0d, got %0d %0d",
                                     want.offset, want.status, i_block_offset, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/testbench.sv */
module testbench;
    import btnf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The limit covers the reset clear of the whole heap memory and walks over
    // a heap of minimum blocks.
    localparam int CYCLE_LIMIT = 50_000_000;
    localparam int SETTLE      = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [0:0]         op = OP_ALLOC;
    logic [REQ_W-1:0]   request_bytes = '0;
    logic [OFF_W-1:0]   free_offset = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [OFF_W-1:0]   block_offset;
    logic [ST_W-1:0]    status;
    logic               cfg_we = 1'b0;
    logic [CHUNK_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int                 cycles = 0;
    int                 words_sent = 0;
    int                 words_back = 0;
    int                 oom_seen = 0;
    bit                 calm_sender = 0;
    bit                 calm_receiver = 0;
    logic [OFF_W-1:0]   live_blocks [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    boundary_tag_next_fit_allocator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_request_bytes(request_bytes), .i_free_offset(free_offset),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_block_offset(block_offset), .o_status(status),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    btnf_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_request_bytes(request_bytes), .i_free_offset(free_offset),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_block_offset(block_offset), .i_status(status),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall per word, one long hold-off to back up the block,
    // and remember every allocated payload so frees can target live blocks.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (words_back == 120) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else begin
                gap = calm_receiver ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            words_back++;
            if (status == ST_OK && block_offset != 0) live_blocks.push_back(block_offset);
            if (status == ST_OOM) oom_seen++;
        end
    end

    // Hold the word until accepted; drop valid only when a gap is drawn.
    task automatic send_word(logic [0:0] kind, logic [REQ_W-1:0] req,
                             logic [OFF_W-1:0] off);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        request_bytes <= req;
        free_offset <= off;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
    endtask

    task automatic alloc_word(logic [REQ_W-1:0] req);
        send_word(OP_ALLOC, req, OFF_W'($urandom));
    endtask

    task automatic free_live();
        int pick;
        logic [OFF_W-1:0] off;
        if (live_blocks.size() == 0) begin
            send_word(OP_FREE, REQ_W'($urandom), OFF_W'($urandom));
            return;
        end
        pick = $urandom_range(0, live_blocks.size() - 1);
        off = live_blocks[pick];
        live_blocks.delete(pick);
        send_word(OP_FREE, REQ_W'($urandom), off);
    endtask

    // Let every answer drain, then let the unit settle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_chunk(logic [CHUNK_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) send_word(OP_FREE, REQ_W'($urandom), OFF_W'($urandom));
        else if (roll < 45) free_live();
        else if (roll < 47) alloc_word(REQ_W'($urandom));
        else if (roll < 52) alloc_word(REQ_W'($urandom_range(1025, 8192)));
        else if (roll < 70) alloc_word(REQ_W'($urandom_range(65, 1024)));
        else alloc_word(REQ_W'($urandom_range(1, 64)));
    endtask

    initial begin
        logic [OFF_W-1:0] first_blk;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: size edges, zero and oversized requests, bad frees.
        alloc_word(16'd0);
        alloc_word(16'd1);
        alloc_word(16'd8);
        alloc_word(16'd9);
        alloc_word(16'hFFFF);
        alloc_word(16'd4000);
        alloc_word(16'd100);
        drain();
        first_blk = live_blocks[0];
        send_word(OP_FREE, 16'd0, 16'd0);
        send_word(OP_FREE, 16'd0, 16'd8);
        send_word(OP_FREE, 16'd0, 16'hFFFF);
        send_word(OP_FREE, 16'd0, first_blk + 16'd8);
        send_word(OP_FREE, 16'hFFFF, first_blk);
        send_word(OP_FREE, 16'd0, first_blk);
        drain();
        // Free neighbors in different orders to hit merges with the next block and with both.
        while (live_blocks.size() > 0) begin
            send_word(OP_FREE, 16'd0, live_blocks[live_blocks.size() - 1]);
            void'(live_blocks.pop_back());
        end
        alloc_word(16'd24);
        alloc_word(16'd24);
        alloc_word(16'd24);
        drain();
        send_word(OP_FREE, 16'd0, live_blocks[0]);
        send_word(OP_FREE, 16'd0, live_blocks[2]);
        send_word(OP_FREE, 16'd0, live_blocks[1]);
        live_blocks.delete();

        // Random phases across chunk settings, extremes included.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_chunk(CHUNK_W'(MIN_BLOCK));
                1: write_chunk(17'h10000);
                2: write_chunk(17'h1FFFF);
                3: write_chunk(17'd24);
                default: write_chunk(CHUNK_W'($urandom_range(2, 1024) * 8));
            endcase
            for (int k = 0; k < 120; k++) begin
                if (k % 40 == 0) begin
                    calm_sender = ($urandom_range(0, 3) == 0);
                    calm_receiver = ($urandom_range(0, 3) == 0);
                end
                random_word();
            end
        end
        write_chunk(CHUNK_W'(INIT_CHUNK));
        calm_sender = 0;
        // Fill the heap until it runs out.
        for (int k = 0; k < 20; k++) alloc_word(16'd8192);

        drain();
        $display("sent %0d words, %0d answers checked, %0d out-of-memory answers",
                 words_sent, words_back, oom_seen);
        $display("covered six chunk settings, bad frees, merges and heap growth");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/btnf_pkg.sv
design/btnf_ram.sv
design/boundary_tag_next_fit_allocator_unit.sv
test/btnf_checker.sv
test/testbench.sv
